>>> src/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg: shared types for the checked signed ALU
// Command and status codes, plus the control word that travels with each
// transaction down the cell chain.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int PORT_WIDTH     = 64;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIVZERO  = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    cmd_t    cmd;
    logic    neg;    // result sign for mul/div
    status_t st;     // status known up front (add/sub/div special cases)
  } csa_ctl_t;

endpackage

>>> src/csa_in_if.sv
// ----------------------------------------------------------------------------
// csa_in_if: command channel
// valid/ready handshake carrying one command and two operands.
// ----------------------------------------------------------------------------
interface csa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

>>> src/csa_out_if.sv
// ----------------------------------------------------------------------------
// csa_out_if: result channel
// valid/ready handshake carrying one result and its status.
// ----------------------------------------------------------------------------
interface csa_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result;
  logic [1:0]         status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

>>> src/csa_front.sv
// ----------------------------------------------------------------------------
// csa_front: decode stage
// Finishes add/sub, flags divide special cases, forms operand magnitudes.
// ----------------------------------------------------------------------------
module csa_front
  import csa_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [1:0]              command,
  input  logic [PORT_WIDTH-1:0]   operand_a,
  input  logic [PORT_WIDTH-1:0]   operand_b,
  output csa_ctl_t                ctl,
  output logic [DATA_WIDTH-1:0]   ma,
  output logic [DATA_WIDTH-1:0]   mb,
  output logic [2*DATA_WIDTH-1:0] acc
);
  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] WSIGN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] a, b, sum, diff;
  logic         sa, sb;
  csa_ctl_t     ctl_next;
  logic [W-1:0] early;

  assign a    = operand_a[W-1:0];
  assign b    = operand_b[W-1:0];
  assign sa   = a[W-1];
  assign sb   = b[W-1];
  assign sum  = a + b;
  assign diff = a - b;

  always_comb begin
    ctl_next.valid = in_valid;
    ctl_next.cmd   = cmd_t'(command);
    ctl_next.neg   = sa ^ sb;
    ctl_next.st    = ST_OK;
    early          = '0;
    unique case (cmd_t'(command))
      CMD_ADD: begin
        if (sa == sb && sum[W-1] != sa) ctl_next.st = ST_OVERFLOW;
        else early = sum;
      end
      CMD_SUB: begin
        if (sa != sb && diff[W-1] != sa) ctl_next.st = ST_OVERFLOW;
        else early = diff;
      end
      CMD_MUL: ;
      CMD_DIV: begin
        if (b == '0) ctl_next.st = ST_DIVZERO;
        else if (a == WSIGN && b == '1) ctl_next.st = ST_OVERFLOW;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl.valid <= ctl_next.valid;
    end
    if (adv) begin
      ctl.cmd <= ctl_next.cmd;
      ctl.neg <= ctl_next.neg;
      ctl.st  <= ctl_next.st;
      ma      <= sa ? W'(0) - a : a;
      mb      <= sb ? W'(0) - b : b;
      acc     <= {{W{1'b0}}, early};
    end
  end
endmodule

>>> src/csa_cell.sv
// ----------------------------------------------------------------------------
// csa_cell: one bit step of multiply and divide
// Shift-add multiply and restoring divide, one operand bit per cell, MSB first.
// ----------------------------------------------------------------------------
module csa_cell
  import csa_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int STEP       = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  csa_ctl_t                ctl_i,
  input  logic [DATA_WIDTH-1:0]   ma_i,
  input  logic [DATA_WIDTH-1:0]   mb_i,
  input  logic [2*DATA_WIDTH-1:0] acc_i,
  input  logic [DATA_WIDTH-1:0]   rem_i,
  input  logic [DATA_WIDTH-1:0]   q_i,
  output csa_ctl_t                ctl_o,
  output logic [DATA_WIDTH-1:0]   ma_o,
  output logic [DATA_WIDTH-1:0]   mb_o,
  output logic [2*DATA_WIDTH-1:0] acc_o,
  output logic [DATA_WIDTH-1:0]   rem_o,
  output logic [DATA_WIDTH-1:0]   q_o
);
  localparam int W   = DATA_WIDTH;
  localparam int BIT = W - 1 - STEP;

  logic [2*W-1:0] acc_next;
  logic [W:0]     trial;
  logic           ge;

  // multiply: acc = 2*acc + (b bit ? a : 0); add/sub results pass untouched
  always_comb begin
    acc_next = acc_i;
    if (ctl_i.cmd == CMD_MUL) begin
      acc_next = {acc_i[2*W-2:0], 1'b0} + (mb_i[BIT] ? {{W{1'b0}}, ma_i} : '0);
    end
  end

  assign trial = {rem_i, ma_i[BIT]};
  assign ge    = trial >= {1'b0, mb_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o.valid <= 1'b0;
    end else if (adv) begin
      ctl_o.valid <= ctl_i.valid;
    end
    if (adv) begin
      ctl_o.cmd <= ctl_i.cmd;
      ctl_o.neg <= ctl_i.neg;
      ctl_o.st  <= ctl_i.st;
      ma_o      <= ma_i;
      mb_o      <= mb_i;
      acc_o     <= acc_next;
      rem_o     <= ge ? W'(trial - {1'b0, mb_i}) : W'(trial);
      q_o       <= {q_i[W-2:0], ge};
    end
  end
endmodule

>>> src/csa_back.sv
// ----------------------------------------------------------------------------
// csa_back: result stage
// Range check and sign for mul/div, zeroing on error, output register.
// ----------------------------------------------------------------------------
module csa_back
  import csa_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  csa_ctl_t                ctl,
  input  logic [2*DATA_WIDTH-1:0] acc,
  input  logic [DATA_WIDTH-1:0]   q,
  output logic                    out_valid,
  output logic [PORT_WIDTH-1:0]   result,
  output logic [1:0]              status
);
  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] WSIGN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]        lo, limit;
  logic signed [W-1:0] res;
  status_t             st;

  assign lo    = acc[W-1:0];
  assign limit = ctl.neg ? WSIGN : WSIGN - W'(1);

  always_comb begin
    st  = ctl.st;
    res = '0;
    unique case (ctl.cmd) inside
      CMD_ADD, CMD_SUB: res = lo;
      CMD_MUL: begin
        if (acc[2*W-1:W] != '0 || lo > limit) st = ST_OVERFLOW;
        else res = ctl.neg ? W'(0) - lo : lo;
      end
      CMD_DIV: res = ctl.neg ? W'(0) - q : q;
      default: ;
    endcase
    if (st != ST_OK) res = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl.valid;
    end
    if (adv) begin
      result <= PORT_WIDTH'(res);
      status <= st;
    end
  end
endmodule

>>> src/checked_signed_alu_top.sv
// ----------------------------------------------------------------------------
// checked_signed_alu_top: signed ALU with overflow and divide-by-zero status
// Add, subtract, multiply, divide (toward zero) on DATA_WIDTH-bit operands.
// ----------------------------------------------------------------------------
// Usage:
//   req : command (0 add, 1 sub, 2 mul, 3 div), operand_a, operand_b.
//         Only the low DATA_WIDTH bits of each operand are used.
//   rsp : result (sign extended to 64 bits) and status
//         (0 ok, 1 overflow, 2 divide by zero). result is zero on error.
//   Every transaction, whatever the command, runs through the same pipe:
//   one decode stage, DATA_WIDTH bit cells and one output register.
//   Throughput is one transaction per cycle while rsp is not stalled; each
//   cell retires one operand bit of the shift-add multiply and the restoring
//   divide, and the 2W-bit accumulator add in a cell sets the cycle time.
//   Results come out in request order.
//   Reset clears only the stage valid bits; the pipe is empty afterwards.
//   When rsp stalls with a result waiting, the whole pipe holds and
//   req.ready drops in the same cycle; it rises again as soon as the
//   waiting result is taken or the output slot is empty.
// ----------------------------------------------------------------------------
module checked_signed_alu_top
  import csa_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst,
  csa_in_if.sink  req,
  csa_out_if.source rsp
);
  localparam int W = DATA_WIDTH;

  // pipe advances unless a finished result is held by the receiver
  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // chain signals: index 0 feeds the first cell, index W leaves the last
  csa_ctl_t       ctl [W+1];
  logic [W-1:0]   ma  [W+1];
  logic [W-1:0]   mb  [W+1];
  logic [2*W-1:0] acc [W+1];
  logic [W-1:0]   rem [W+1];
  logic [W-1:0]   q   [W+1];

  assign rem[0] = '0;
  assign q[0]   = '0;

  csa_front #(.DATA_WIDTH(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (req.valid),
    .command   (req.command),
    .operand_a (req.operand_a),
    .operand_b (req.operand_b),
    .ctl       (ctl[0]),
    .ma        (ma[0]),
    .mb        (mb[0]),
    .acc       (acc[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    csa_cell #(.DATA_WIDTH(W), .STEP(i)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .ctl_i (ctl[i]),
      .ma_i  (ma[i]),
      .mb_i  (mb[i]),
      .acc_i (acc[i]),
      .rem_i (rem[i]),
      .q_i   (q[i]),
      .ctl_o (ctl[i+1]),
      .ma_o  (ma[i+1]),
      .mb_o  (mb[i+1]),
      .acc_o (acc[i+1]),
      .rem_o (rem[i+1]),
      .q_o   (q[i+1])
    );
  end

  csa_back #(.DATA_WIDTH(W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl       (ctl[W]),
    .acc       (acc[W]),
    .q         (q[W]),
    .out_valid (rsp.valid),
    .result    (rsp.result),
    .status    (rsp.status)
  );

`ifndef SYNTHESIS
  // unused status code never leaves the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status != 2'd3)
    else $error("status code 3 produced");

  // any error reports a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.result == '0)
    else $error("nonzero result on error");

  // output slot fills from the last cell whenever the pipe moves
  a_out_follow: assert property (@(posedge clk) disable iff (rst)
    adv |=> rsp.valid == $past(ctl[W].valid))
    else $error("output valid lost or invented");

  // a held result keeps the whole pipe frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> $stable(ctl[W].valid) && $stable(acc[W]))
    else $error("pipe moved during stall");
`endif
endmodule
